// ----- hw/rtl/cdq_pkg.sv -----
// Package for the circular deque: sizes, command codes, index helpers and
// the command bundle that the controller sends to the datapath.
// No dependencies.
`timescale 1ns / 1ps

package cdq_pkg;

	localparam int CAPACITY   = 16;
	localparam int DATA_WIDTH = 32;
	localparam int IDX_W      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

	localparam int CMD_W   = 2;
	localparam int FIELD_W = 32;

	typedef logic [IDX_W-1:0]      idx_t;
	typedef logic [DATA_WIDTH-1:0] data_t;
	typedef logic [CMD_W-1:0]      cmd_t;
	typedef logic [FIELD_W-1:0]    field_t;

	localparam cmd_t CMD_PUSH_BACK  = 2'd0;
	localparam cmd_t CMD_PUSH_FRONT = 2'd1;
	localparam cmd_t CMD_POP_FRONT  = 2'd2;
	localparam cmd_t CMD_POP_BACK   = 2'd3;

	localparam idx_t IDX_LAST = IDX_W'(CAPACITY - 1);

	// Controller to datapath: capture the accepted item, execute it,
	// load the result into the output register.
	typedef struct packed {
		logic capture;
		logic exec;
		logic load_out;
	} dp_cmd_t;

	function automatic idx_t next_idx(input idx_t i);
		return (i == IDX_LAST) ? '0 : idx_t'(i + 1'b1);
	endfunction

	function automatic idx_t prev_idx(input idx_t i);
		return (i == '0) ? IDX_LAST : idx_t'(i - 1'b1);
	endfunction

	// Keeps the low DATA_WIDTH bits of a pushed value.
	function automatic data_t to_data(input field_t v);
		logic [63:0] w;
		w = {32'd0, v};
		return w[DATA_WIDTH-1:0];
	endfunction

	// Low 32 bits of a stored element, zero extended when it is narrower.
	function automatic field_t to_field(input data_t d);
		logic [63:0] w;
		w = 64'(d);
		return w[FIELD_W-1:0];
	endfunction

endpackage

// ----- hw/rtl/cdq_if.sv -----
// Channel interfaces of the circular deque: command input and result output.
// Depends on cdq_pkg.
`timescale 1ns / 1ps

interface cdq_in_if;
	logic            valid;
	logic            ready;
	cdq_pkg::cmd_t   cmd;
	cdq_pkg::field_t push_value;

	modport source (output valid, output cmd, output push_value, input ready);
	modport sink   (input valid, input cmd, input push_value, output ready);
endinterface

interface cdq_out_if;
	logic            valid;
	logic            ready;
	logic            ok;
	cdq_pkg::field_t pop_value;
	logic            is_empty;
	logic            is_full;

	modport source (output valid, output ok, output pop_value, output is_empty,
		output is_full, input ready);
	modport sink   (input valid, input ok, input pop_value, input is_empty,
		input is_full, output ready);
endinterface

// ----- hw/rtl/cdq_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module cdq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                                     clk,
	input  logic                                     wr_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                         wr_data,
	input  logic                                     rd_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// ----- hw/rtl/cdq_ctrl.sv -----
// Sequencing controller of the circular deque: accept, execute, respond.
// Holds the output valid flag. Depends on cdq_pkg.
`timescale 1ns / 1ps

module cdq_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	output logic             out_valid,
	input  logic             out_ready,
	output cdq_pkg::dp_cmd_t dp_cmd
);
	import cdq_pkg::*;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_EXEC = 2'd1;
	localparam logic [1:0] S_RESP = 2'd2;

	logic [1:0] state_q;
	logic       out_valid_q;
	logic       in_xfer;
	logic       load_out;

	assign in_ready = (state_q == S_IDLE);
	assign in_xfer  = in_valid && in_ready;
	// The result register is free when empty or being drained this cycle.
	assign load_out = (state_q == S_RESP) && (!out_valid_q || out_ready);

	assign dp_cmd.capture  = in_xfer;
	assign dp_cmd.exec     = (state_q == S_EXEC);
	assign dp_cmd.load_out = load_out;
	assign out_valid       = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_xfer) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					state_q <= S_RESP;
				end
				S_RESP: begin
					if (load_out) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

`ifndef ASSERT_OFF
	a_accept_to_exec: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> state_q == S_EXEC)
		else $error("accepted item did not enter execution");
	a_exec_to_resp: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_EXEC |=> state_q == S_RESP)
		else $error("execution did not move to response");
	a_load_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |=> out_valid_q)
		else $error("result load did not raise output valid");
`endif

endmodule

// ----- hw/rtl/cdq_datapath.sv -----
// Datapath of the circular deque: head and tail indices, empty flag, slot
// RAM and result register. Depends on cdq_pkg and cdq_ram.
`timescale 1ns / 1ps

module cdq_datapath (
	input  logic             clk,
	input  logic             arst_n,
	input  cdq_pkg::dp_cmd_t dp_cmd,
	input  cdq_pkg::cmd_t    in_cmd,
	input  cdq_pkg::field_t  in_push_value,
	output logic             out_ok,
	output cdq_pkg::field_t  out_pop_value,
	output logic             out_is_empty,
	output logic             out_is_full
);
	import cdq_pkg::*;

	cmd_t   cmd_q;
	field_t value_q;
	idx_t   head_q;
	idx_t   tail_q;
	logic   empty_q;
	logic   ok_q;
	logic   popped_q;

	logic   ok_out_q;
	field_t pop_value_q;
	logic   empty_out_q;
	logic   full_out_q;

	logic   full_w;
	logic   is_push;
	logic   push_ok;
	logic   pop_ok;
	logic   wr_en;
	logic   rd_en;
	idx_t   wr_addr;
	idx_t   rd_addr;
	data_t  rd_data;

	assign full_w  = !empty_q && (next_idx(tail_q) == head_q);
	assign is_push = (cmd_q == CMD_PUSH_BACK) || (cmd_q == CMD_PUSH_FRONT);
	assign push_ok = is_push && !full_w;
	assign pop_ok  = !is_push && !empty_q;
	assign wr_en   = dp_cmd.exec && push_ok;
	assign rd_en   = dp_cmd.exec && pop_ok;

	always_comb begin
		wr_addr = '0;
		rd_addr = head_q;
		case (cmd_q)
			CMD_PUSH_BACK:  wr_addr = empty_q ? '0 : next_idx(tail_q);
			CMD_PUSH_FRONT: wr_addr = empty_q ? IDX_LAST : prev_idx(head_q);
			CMD_POP_FRONT:  rd_addr = head_q;
			CMD_POP_BACK:   rd_addr = tail_q;
			default:        rd_addr = head_q;
		endcase
	end

	cdq_ram #(
		.WIDTH (DATA_WIDTH),
		.DEPTH (CAPACITY)
	) u_slots (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (to_data(value_q)),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk) begin
		if (dp_cmd.capture) begin
			cmd_q   <= in_cmd;
			value_q <= in_push_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q   <= '0;
			tail_q   <= '0;
			empty_q  <= 1'b1;
			ok_q     <= 1'b0;
			popped_q <= 1'b0;
		end else if (dp_cmd.exec) begin
			ok_q     <= push_ok || pop_ok;
			popped_q <= pop_ok;
			if (push_ok) begin
				empty_q <= 1'b0;
				if (cmd_q == CMD_PUSH_BACK) begin
					tail_q <= wr_addr;
					if (empty_q) begin
						head_q <= wr_addr;
					end
				end else begin
					head_q <= wr_addr;
					if (empty_q) begin
						tail_q <= wr_addr;
					end
				end
			end else if (pop_ok) begin
				if (head_q == tail_q) begin
					// Last element leaves: back to the reset picture.
					empty_q <= 1'b1;
					head_q  <= '0;
					tail_q  <= '0;
				end else if (cmd_q == CMD_POP_FRONT) begin
					head_q <= next_idx(head_q);
				end else begin
					tail_q <= prev_idx(tail_q);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (dp_cmd.load_out) begin
			ok_out_q    <= ok_q;
			pop_value_q <= popped_q ? to_field(rd_data) : '0;
			empty_out_q <= empty_q;
			full_out_q  <= full_w;
		end
	end

	assign out_ok        = ok_out_q;
	assign out_pop_value = pop_value_q;
	assign out_is_empty  = empty_out_q;
	assign out_is_full   = full_out_q;

`ifndef ASSERT_OFF
	a_empty_indices: assert property (@(posedge clk) disable iff (!arst_n)
		empty_q |-> (head_q == '0) && (tail_q == '0))
		else $error("empty queue with nonzero indices");
	a_refused_zero: assert property (@(posedge clk) disable iff (!arst_n)
		dp_cmd.load_out && !popped_q |=> pop_value_q == '0)
		else $error("nonzero pop value without a pop");
	a_one_access: assert property (@(posedge clk) disable iff (!arst_n)
		!(wr_en && rd_en))
		else $error("slot RAM written and read by the same command");
`endif

endmodule

// ----- hw/rtl/circular_deque.sv -----
// Top level of the circular deque: controller, datapath and channel ports.
// Depends on cdq_pkg, cdq_if, cdq_ctrl and cdq_datapath.
`timescale 1ns / 1ps

// A fixed-capacity double-ended queue of CAPACITY elements kept in a
// circular slot RAM. Each input transfer carries a command (push back, push
// front, pop front, pop back) and a value, and produces exactly one result
// transfer with a success flag, the popped value (zero for pushes and for
// refused commands) and the empty and full flags after the command. A push
// into a full queue and a pop from an empty queue are refused and change
// nothing. From input transfer to result, each command is first captured,
// then updates the indices and accesses the slot RAM, and then the RAM's
// registered read lands in the result register once that is free.
// The controller handles one command at a time, so a new command is not
// accepted until the previous one has reached the result register. A new
// command is accepted while the previous result still waits in the output
// register. There is no clearing pass after reset: the slots need none,
// since a pop only ever reads a slot that an earlier push wrote.
module circular_deque (
	input  logic      clk,
	input  logic      arst_n,
	cdq_in_if.sink    in_ch,
	cdq_out_if.source out_ch
);
	import cdq_pkg::*;

	dp_cmd_t dp_cmd;

	// Sequencer: owns in_ch.ready and out_ch.valid.
	cdq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ch.ready),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.dp_cmd    (dp_cmd)
	);

	// Queue state, slot RAM and the result payload register.
	cdq_datapath u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.dp_cmd        (dp_cmd),
		.in_cmd        (in_ch.cmd),
		.in_push_value (in_ch.push_value),
		.out_ok        (out_ch.ok),
		.out_pop_value (out_ch.pop_value),
		.out_is_empty  (out_ch.is_empty),
		.out_is_full   (out_ch.is_full)
	);

endmodule
